// File: hdl/tt800_random_word_generator_assert.svh
// Assertion macros for the TT800 word generator.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef TT800_RANDOM_WORD_GENERATOR_ASSERT_SVH
`define TT800_RANDOM_WORD_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TT800_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tt800 assertion failed");

// Next-cycle implication, disabled during reset
`define TT800_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tt800 assertion failed");

`endif

// File: hdl/tt800_pkg.sv
// Shared constants and helpers for the TT800 word generator.
// No dependencies.
package tt800_pkg;

    localparam int STATE_WORDS_DEF = 25;
    localparam int TAP_OFFSET_DEF  = 7;

    localparam int WORD_W = 32;
    localparam int SEED_W = 31;
    localparam int PM_A_W = 15;
    localparam int PROD_W = SEED_W + PM_A_W;

    // Park-Miller minimal standard: multiplier and modulus 2^31-1
    localparam logic [PM_A_W-1:0] PM_A = 15'd16807;
    localparam logic [SEED_W-1:0] PM_M = 31'h7fff_ffff;

    localparam logic [WORD_W-1:0] TWIST_XOR = 32'h8ebf_d028;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h2b5b_2500;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hdb8b_0000;

    // Input mode codes
    localparam logic MODE_DRAW   = 1'b0;
    localparam logic MODE_RESEED = 1'b1;

    // Output tempering of one ring word
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
        logic [WORD_W-1:0] y;
        y = y_in;
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 16);
        return y;
    endfunction

endpackage

// File: hdl/tt800_if.sv
// Stream interfaces for the TT800 word generator: command in, word out.
// Depends on tt800_pkg for field widths.
interface tt800_in_if import tt800_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SEED_W-1:0] seed_value;

    modport source (output valid, mode, seed_value, input ready);
    modport sink   (input valid, mode, seed_value, output ready);
endinterface

interface tt800_out_if import tt800_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, random_word, input ready);
    modport sink   (input valid, random_word, output ready);
endinterface

// File: hdl/tt800_ring.sv
// State ring memory: one write port, two registered read ports.
// Per-entry valid bits make unwritten words read as zero. Uses tt800_pkg.
module tt800_ring import tt800_pkg::*; #(
    parameter int STATE_WORDS = STATE_WORDS_DEF,
    localparam int IDX_W = $clog2(STATE_WORDS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]  i_raddr_a,
    input  logic [IDX_W-1:0]  i_raddr_b,
    output logic [WORD_W-1:0] o_rdata_a,
    output logic [WORD_W-1:0] o_rdata_b
);

    logic [WORD_W-1:0]      r_mem [STATE_WORDS];
    logic [STATE_WORDS-1:0] r_valid;
    logic [WORD_W-1:0]      r_rdata_a;
    logic [WORD_W-1:0]      r_rdata_b;
    logic                   r_rvalid_a;
    logic                   r_rvalid_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        r_rdata_a  <= r_mem[i_raddr_a];
        r_rdata_b  <= r_mem[i_raddr_b];
        r_rvalid_a <= r_valid[i_raddr_a];
        r_rvalid_b <= r_valid[i_raddr_b];
    end

    assign o_rdata_a = r_rvalid_a ? r_rdata_a : '0;
    assign o_rdata_b = r_rvalid_b ? r_rdata_b : '0;

endmodule

// File: hdl/tt800_random_word_generator.sv
// TT800 twisted-GFSR word generator: top level with sequencer and Park-Miller unit.
// Depends on tt800_pkg, tt800_if, tt800_ring and the assertion macro header.
//
//  Channel | Dir | Payload                    | Transfer
//  i_in    | in  | mode, seed_value           | valid && ready
//  o_out   | out | random_word (draws only)   | valid && ready
//
// A draw passes through the ring's registered read port, then the twist/temper step in S_DRAW.
// In a reseed the shared multiply and modulus fold run once per ring word,
// in states S_MUL and S_FOLD.
// i_in.ready is high only while the sequencer is idle.
// A draw holds in its twist cycle while the output register is full and not taken.
// Reset clears the ring's valid bits at once; there is no clearing pass.
`include "tt800_random_word_generator_assert.svh"

module tt800_random_word_generator import tt800_pkg::*; #(
    parameter int STATE_WORDS = STATE_WORDS_DEF,
    parameter int TAP_OFFSET  = TAP_OFFSET_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tt800_in_if.sink     i_in,
    tt800_out_if.source  o_out
);

    localparam int IDX_W = $clog2(STATE_WORDS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DRAW = 4'b0010,
        S_MUL  = 4'b0100,
        S_FOLD = 4'b1000
    } t_state;

    t_state              r_state,  n_state;
    logic [IDX_W-1:0]    r_pos,    n_pos;
    logic [IDX_W-1:0]    r_cnt,    n_cnt;
    logic [SEED_W-1:0]   r_lcg,    n_lcg;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_word,  n_out_word;

    logic                in_xfer;
    logic                out_free;
    logic [IDX_W:0]      tap_sum;
    logic [IDX_W-1:0]    tap_idx;
    logic [IDX_W:0]      pos_sum;
    logic [IDX_W-1:0]    pos_inc;
    logic [WORD_W-1:0]   cur_word;
    logic [WORD_W-1:0]   tap_word;
    logic [WORD_W-1:0]   twist_word;
    logic [WORD_W-1:0]   fold_sum;
    logic [SEED_W-1:0]   fold_res;
    logic                ring_we;
    logic [IDX_W-1:0]    ring_waddr;
    logic [WORD_W-1:0]   ring_wdata;

    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Tap and next position, both modulo STATE_WORDS
    always_comb begin
        tap_sum = (IDX_W+1)'(r_pos) + (IDX_W+1)'(TAP_OFFSET);
        if (tap_sum >= (IDX_W+1)'(STATE_WORDS)) begin
            tap_sum = tap_sum - (IDX_W+1)'(STATE_WORDS);
        end
        tap_idx = tap_sum[IDX_W-1:0];
        pos_sum = (IDX_W+1)'(r_pos) + (IDX_W+1)'(1);
        if (pos_sum >= (IDX_W+1)'(STATE_WORDS)) begin
            pos_sum = '0;
        end
        pos_inc = pos_sum[IDX_W-1:0];
    end

    // Ring memory; reads are issued every cycle at the current position
    tt800_ring #(
        .STATE_WORDS (STATE_WORDS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (ring_we),
        .i_waddr   (ring_waddr),
        .i_wdata   (ring_wdata),
        .i_raddr_a (r_pos),
        .i_raddr_b (tap_idx),
        .o_rdata_a (cur_word),
        .o_rdata_b (tap_word)
    );

    // Twist of current word with the tap word
    assign twist_word = tap_word ^ (cur_word >> 1) ^ (cur_word[0] ? TWIST_XOR : '0);

    // Park-Miller fold: 16807*x mod (2^31-1) as hi + lo, one conditional subtract
    always_comb begin
        fold_sum = WORD_W'(r_prod[PROD_W-1:SEED_W]) + WORD_W'(r_prod[SEED_W-1:0]);
        if (fold_sum >= WORD_W'(PM_M)) begin
            fold_sum = fold_sum - WORD_W'(PM_M);
        end
        fold_res = fold_sum[SEED_W-1:0];
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_lcg       = r_lcg;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        ring_we     = 1'b0;
        ring_waddr  = r_pos;
        ring_wdata  = twist_word;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.mode == MODE_RESEED) begin
                        n_lcg   = i_in.seed_value;
                        n_cnt   = '0;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
            end
            S_DRAW: begin
                if (out_free) begin
                    ring_we     = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_word  = temper(cur_word);
                    n_pos       = pos_inc;
                    n_state     = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_FOLD;
            end
            S_FOLD: begin
                ring_we    = 1'b1;
                ring_waddr = r_cnt;
                ring_wdata = WORD_W'(fold_res);
                n_lcg      = fold_res;
                if (r_cnt == IDX_W'(STATE_WORDS - 1)) begin
                    n_pos   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + IDX_W'(1);
                    n_state = S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_lcg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_lcg       <= n_lcg;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: product and output word
    always_ff @(posedge i_clk) begin
        r_prod     <= PROD_W'(r_lcg) * PROD_W'(PM_A);
        r_out_word <= n_out_word;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.random_word = r_out_word;

    // Checks
    `TT800_ASSERT_NOW(a_pos_range, 1'b1, r_pos < IDX_W'(STATE_WORDS))
    `TT800_ASSERT_NEXT(a_draw_seq, in_xfer && (i_in.mode == MODE_DRAW), r_state == S_DRAW)
    `TT800_ASSERT_NOW(a_fill_range, r_state == S_FOLD, r_cnt < IDX_W'(STATE_WORDS))
    `TT800_ASSERT_NOW(a_out_src, $rose(r_out_valid), $past(r_state == S_DRAW))

endmodule
